// File: src/assert_macros.svh
// assertion macros for the rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check a property on every rising clock edge outside reset
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cpualu assertion failed");

// check a property on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("cpualu assertion failed");

`else

`define ASSERT_CHK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: src/cpualu_pkg.sv
// types and constants of the 8-bit alu with flags
package cpualu_pkg;

  // operation codes
  typedef enum logic [4:0] {
    OP_INC   = 5'd0,
    OP_DEC   = 5'd1,
    OP_ADD   = 5'd2,
    OP_ADC   = 5'd3,
    OP_SUB   = 5'd4,
    OP_SBC   = 5'd5,
    OP_AND   = 5'd6,
    OP_OR    = 5'd7,
    OP_XOR   = 5'd8,
    OP_CP    = 5'd9,
    OP_ADD16 = 5'd10,
    OP_ADC16 = 5'd11,
    OP_SBC16 = 5'd12,
    OP_RRD   = 5'd13,
    OP_RLD   = 5'd14,
    OP_RLCA  = 5'd15,
    OP_RRCA  = 5'd16,
    OP_RLA   = 5'd17,
    OP_RRA   = 5'd18,
    OP_CPL   = 5'd19,
    OP_NEG   = 5'd20,
    OP_RLC   = 5'd21,
    OP_RRC   = 5'd22,
    OP_RL    = 5'd23,
    OP_RR    = 5'd24,
    OP_SLA   = 5'd25,
    OP_SRA   = 5'd26,
    OP_SLL   = 5'd27,
    OP_SRL   = 5'd28
  } alu_op_e;

  // flag bit positions, S Z Y H X P/V N C from bit 7 down
  localparam int unsigned FlagS = 7;
  localparam int unsigned FlagZ = 6;
  localparam int unsigned FlagY = 5;
  localparam int unsigned FlagH = 4;
  localparam int unsigned FlagX = 3;
  localparam int unsigned FlagP = 2;
  localparam int unsigned FlagN = 1;
  localparam int unsigned FlagC = 0;

  // flag masks
  localparam logic [7:0] MaskS53  = 8'hA8;
  localparam logic [7:0] Mask53   = 8'h28;
  localparam logic [7:0] MaskSZP  = 8'hC4;
  localparam logic [7:0] MaskSZPC = 8'hC5;
  localparam logic [7:0] MaskHN   = 8'h12;

  // one input beat
  typedef struct packed {
    logic [4:0]  op;
    logic [7:0]  acc_in;
    logic [7:0]  flags_in;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [7:0]  mem_byte;
  } alu_in_t;

  // one result beat
  typedef struct packed {
    logic [15:0] value_out;
    logic [7:0]  acc_out;
    logic [7:0]  flags_out;
    logic [7:0]  mem_write;
  } alu_res_t;

endpackage

// File: src/cpu_alu_8bit_with_flags.sv
// 8-bit cpu alu with flag byte, input register and result register
//
//  channel  | ports                  | handshake
//  ---------+------------------------+-----------------------------------
//  input    | in_i  (alu_in_t)       | beat taken when start && !busy
//  result   | res_o (alu_res_t)      | beat valid for one cycle on done_o
//
// every beat passes from start to done_o through the input register, then
// through the operation logic into the result register.
// busy stays low, so a new beat is taken in every cycle.
// reset clears the two valid flags only; payload registers are not reset.
// the receiver cannot stall: each result is shown for exactly one cycle.
`include "assert_macros.svh"

module cpu_alu_8bit_with_flags import cpualu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  alu_in_t  in_i,
  output logic     done_o,
  output alu_res_t res_o
);

  // 8-bit add or subtract, returns {flags, result}
  function automatic logic [15:0] arith8(input logic [7:0] a, input logic [7:0] v,
                                         input logic c, input logic sub);
    logic [8:0] r9;
    logic [4:0] h5;
    logic       ov;
    logic [7:0] f;
    if (sub) begin
      r9 = {1'b0, a} - {1'b0, v} - {8'h00, c};
      h5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, c};
      ov = (a[7] ^ v[7]) & (a[7] ^ r9[7]);
    end else begin
      r9 = {1'b0, a} + {1'b0, v} + {8'h00, c};
      h5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, c};
      ov = ~(a[7] ^ v[7]) & (a[7] ^ r9[7]);
    end
    f = {r9[7], (r9[7:0] == 8'h00), r9[5], h5[4], r9[3], ov, sub, r9[8]};
    return {f, r9[7:0]};
  endfunction

  // sign, zero, y, x and even parity of a byte
  function automatic logic [7:0] szp(input logic [7:0] r);
    return (r & MaskS53) | {1'b0, (r == 8'h00), 3'b000, ~^r, 2'b00};
  endfunction

  alu_in_t  in_q;
  logic     in_valid_q, in_valid_d;
  alu_res_t res_q, res_d;
  logic     done_q;

  assign busy       = 1'b0;
  assign in_valid_d = start & ~busy;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_d) begin
      in_q <= in_i;
    end
  end

  // operation logic
  logic [7:0]  a, f, v, m, r8, acc, nf, mw;
  logic [15:0] w1, w2, val, arith;
  logic [16:0] r17;
  logic [12:0] h13;
  logic        cin, cb, val_is_acc;

  always_comb begin
    a          = in_q.acc_in;
    f          = in_q.flags_in;
    w1         = in_q.operand_a;
    w2         = in_q.operand_b;
    m          = in_q.mem_byte;
    v          = w1[7:0];
    cin        = f[FlagC];
    acc        = a;
    nf         = f;
    mw         = 8'h00;
    val        = 16'h0000;
    val_is_acc = 1'b1;
    r8         = 8'h00;
    r17        = 17'h00000;
    h13        = 13'h0000;
    cb         = 1'b0;
    arith      = 16'h0000;
    case (alu_op_e'(in_q.op))
      OP_INC: begin
        r8 = v + 8'h01;
        nf = {r8[7], (r8 == 8'h00), r8[5], (r8[3:0] == 4'h0), r8[3],
              (r8 == 8'h80), 1'b0, cin};
        val = {8'h00, r8};
        val_is_acc = 1'b0;
      end
      OP_DEC: begin
        r8 = v - 8'h01;
        nf = {r8[7], (r8 == 8'h00), r8[5], (v[3:0] == 4'h0), r8[3],
              (r8 == 8'h7F), 1'b1, cin};
        val = {8'h00, r8};
        val_is_acc = 1'b0;
      end
      OP_ADD: begin
        arith = arith8(a, v, 1'b0, 1'b0);
        {nf, acc} = arith;
      end
      OP_ADC: begin
        arith = arith8(a, v, cin, 1'b0);
        {nf, acc} = arith;
      end
      OP_SUB: begin
        arith = arith8(a, v, 1'b0, 1'b1);
        {nf, acc} = arith;
      end
      OP_SBC: begin
        arith = arith8(a, v, cin, 1'b1);
        {nf, acc} = arith;
      end
      OP_AND: begin
        acc = a & v;
        nf  = szp(acc);
        nf[FlagH] = 1'b1;
      end
      OP_OR: begin
        acc = a | v;
        nf  = szp(acc);
      end
      OP_XOR: begin
        acc = a ^ v;
        nf  = szp(acc);
      end
      // compare takes y and x from the operand
      OP_CP: begin
        arith = arith8(a, v, 1'b0, 1'b1);
        nf = (arith[15:8] & ~Mask53) | (v & Mask53);
      end
      OP_ADD16: begin
        r17 = {1'b0, w1} + {1'b0, w2};
        h13 = {1'b0, w1[11:0]} + {1'b0, w2[11:0]};
        nf  = (f & MaskSZP) | (r17[15:8] & Mask53);
        nf[FlagH] = h13[12];
        nf[FlagC] = r17[16];
        val = r17[15:0];
        val_is_acc = 1'b0;
      end
      OP_ADC16: begin
        r17 = {1'b0, w1} + {1'b0, w2} + {16'h0000, cin};
        h13 = {1'b0, w1[11:0]} + {1'b0, w2[11:0]} + {12'h000, cin};
        nf  = {r17[15], (r17[15:0] == 16'h0000), r17[13], h13[12], r17[11],
               ~(w1[15] ^ w2[15]) & (w1[15] ^ r17[15]), 1'b0, r17[16]};
        val = r17[15:0];
        val_is_acc = 1'b0;
      end
      OP_SBC16: begin
        r17 = {1'b0, w1} - {1'b0, w2} - {16'h0000, cin};
        h13 = {1'b0, w1[11:0]} - {1'b0, w2[11:0]} - {12'h000, cin};
        nf  = {r17[15], (r17[15:0] == 16'h0000), r17[13], h13[12], r17[11],
               (w1[15] ^ w2[15]) & (w1[15] ^ r17[15]), 1'b1, r17[16]};
        val = r17[15:0];
        val_is_acc = 1'b0;
      end
      // nibble rotates through the memory byte
      OP_RRD: begin
        mw  = {a[3:0], m[7:4]};
        acc = {a[7:4], m[3:0]};
        nf  = szp(acc);
        nf[FlagC] = cin;
      end
      OP_RLD: begin
        mw  = {m[3:0], a[3:0]};
        acc = {a[7:4], m[7:4]};
        nf  = szp(acc);
        nf[FlagC] = cin;
      end
      // accumulator rotates keep s, z and p
      OP_RLCA: begin
        acc = {a[6:0], a[7]};
        nf  = (f & MaskSZP) | (acc & Mask53);
        nf[FlagC] = a[7];
      end
      OP_RRCA: begin
        acc = {a[0], a[7:1]};
        nf  = (f & MaskSZP) | (acc & Mask53);
        nf[FlagC] = a[0];
      end
      OP_RLA: begin
        acc = {a[6:0], cin};
        nf  = (f & MaskSZP) | (acc & Mask53);
        nf[FlagC] = a[7];
      end
      OP_RRA: begin
        acc = {cin, a[7:1]};
        nf  = (f & MaskSZP) | (acc & Mask53);
        nf[FlagC] = a[0];
      end
      OP_CPL: begin
        acc = ~a;
        nf  = (f & MaskSZPC) | (acc & Mask53) | MaskHN;
      end
      OP_NEG: begin
        arith = arith8(8'h00, a, 1'b0, 1'b1);
        {nf, acc} = arith;
      end
      // cb rotates and shifts
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL: begin
        case (alu_op_e'(in_q.op))
          OP_RLC:  begin r8 = {v[6:0], v[7]}; cb = v[7]; end
          OP_RRC:  begin r8 = {v[0], v[7:1]}; cb = v[0]; end
          OP_RL:   begin r8 = {v[6:0], cin};  cb = v[7]; end
          OP_RR:   begin r8 = {cin, v[7:1]};  cb = v[0]; end
          OP_SLA:  begin r8 = {v[6:0], 1'b0}; cb = v[7]; end
          OP_SRA:  begin r8 = {v[7], v[7:1]}; cb = v[0]; end
          OP_SLL:  begin r8 = {v[6:0], 1'b1}; cb = v[7]; end
          default: begin r8 = {1'b0, v[7:1]}; cb = v[0]; end
        endcase
        nf = szp(r8);
        nf[FlagC] = cb;
        val = {8'h00, r8};
        val_is_acc = 1'b0;
      end
      // unused codes leave everything unchanged
      default: begin
      end
    endcase
    if (val_is_acc) begin
      val = {8'h00, acc};
    end
    res_d.value_out = val;
    res_d.acc_out   = acc;
    res_d.flags_out = nf;
    res_d.mem_write = mw;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // every beat in the input register shows up as a result in the next cycle
  `ASSERT_CHK(a_done_follows, in_valid_q |=> done_q)
  `ASSERT_CHK(a_no_spurious_done, !in_valid_q |=> !done_q)
  // only the nibble rotates write memory
  `ASSERT_CHK(a_mem_write_zero, done_q |-> (res_q.mem_write == 8'h00) ||
    ($past(in_q.op) == OP_RRD) || ($past(in_q.op) == OP_RLD))
  // compare leaves the accumulator alone
  `ASSERT_CHK(a_cp_keeps_acc, (done_q && ($past(in_q.op) == OP_CP)) |->
    (res_q.acc_out == $past(in_q.acc_in)))
  // subtraction sets n
  `ASSERT_CHK(a_sub_sets_n, (done_q && ($past(in_q.op) == OP_SUB)) |->
    res_q.flags_out[FlagN])
  `ASSERT_ALWAYS(a_never_busy, !busy)

endmodule
